[rtl/core/assert_macros.svh]
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication under synchronous reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tcprw assertion failed");

// Next-cycle implication under synchronous reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tcprw assertion failed");

`endif

[rtl/core/tcprw_pkg.sv]
// Shared types and constants of the Reno congestion window unit.
package tcprw_pkg;

  typedef logic [1:0] phase_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

  localparam phase_t PH_SLOW    = 2'd0;
  localparam phase_t PH_AVOID   = 2'd1;
  localparam phase_t PH_RECOVER = 2'd2;

  localparam logic CMD_ACK   = 1'b0;
  localparam logic CMD_TIMER = 1'b1;

  localparam logic [1:0] CFG_SEGMENT_SIZE = 2'd0;
  localparam logic [1:0] CFG_INIT_THRESH  = 2'd1;
  localparam logic [1:0] CFG_MIN_TIMEOUT  = 2'd2;
  localparam logic [1:0] CFG_MAX_TIMEOUT  = 2'd3;

  localparam logic [15:0] RST_SEGMENT_SIZE = 16'd100;
  localparam logic [31:0] RST_INIT_THRESH  = 32'd65535;
  localparam logic [7:0]  RST_MIN_TIMEOUT  = 8'd2;
  localparam logic [7:0]  RST_MAX_TIMEOUT  = 8'd10;

  localparam logic [7:0] DUP_TRIGGER  = 8'd3;
  localparam logic [7:0] COUNT_MAX    = 8'd255;
  localparam logic [7:0] STRIKE_LIMIT = 8'd5;

endpackage

[rtl/core/tcprw_divider.sv]
// Restoring divider, one quotient bit per cycle.
module tcprw_divider
  import tcprw_pkg::*;
#(
  parameter int WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [WIDTH-1:0] dividend,
  input  logic [WIDTH-1:0] divisor,
  output div_status_t      status,
  output logic [WIDTH-1:0] quotient,
  output logic [WIDTH-1:0] remainder
);

  localparam int CW = $clog2(WIDTH + 1);

  logic [CW-1:0]    count;
  logic             done;
  logic [WIDTH-1:0] quo;
  logic [WIDTH-1:0] rem;
  logic [WIDTH-1:0] dsr;
  logic [WIDTH:0]   shifted;
  logic [WIDTH:0]   diff;
  logic             fits;

  assign shifted = {rem, quo[WIDTH-1]};
  assign fits    = shifted >= {1'b0, dsr};
  assign diff    = shifted - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        count <= CW'(WIDTH);
      end else if (count != '0) begin
        count <= count - 1'b1;
        if (count == CW'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (count != '0) begin
      quo <= {quo[WIDTH-2:0], fits};
      rem <= fits ? diff[WIDTH-1:0] : shifted[WIDTH-1:0];
    end
  end

  assign status.busy = (count != '0);
  assign status.done = done;
  assign quotient    = quo;
  assign remainder   = rem;

endmodule

[rtl/core/tcp_reno_congestion_window_unit.sv]
// Reno congestion window unit: top level with sequencer, state and output register.
// Sequence: timer items go from track to done; ACKs go from track through the rule
// state to done, via a threshold check when slow start grows the window, and via the
// divider when they grow it in avoidance or trigger fast retransmit with a nonzero MSS.
// Throughput: one item at a time; the next is taken the cycle after the result is
// registered, and a result still waiting on result_ready stalls the one behind it.
// Reset: synchronous; state and config registers reset, window = 100, threshold = 65535.
module tcp_reno_congestion_window_unit
  import tcprw_pkg::*;
#(
  parameter int WINDOW_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        item_valid,
  output logic        item_ready,
  input  logic        command,
  input  logic [31:0] ack_number,
  input  logic        has_outstanding,
  output logic        result_valid,
  input  logic        result_ready,
  output logic [31:0] window_bytes,
  output logic [31:0] threshold_bytes,
  output phase_t      phase,
  output logic        retransmit_oldest,
  output logic        ack_stale,
  output logic [7:0]  duplicate_count,
  output logic [7:0]  timeout_seconds
);

  localparam int W   = WINDOW_WIDTH;
  localparam int WP1 = W + 1;
  localparam int N   = (W > 32) ? W : 32;
  localparam int NP1 = N + 1;
  localparam logic [W-1:0] WIN_MAX   = '1;
  localparam logic [N:0]   WIN_MAX_X = NP1'(WIN_MAX);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_TRACK = 4'd1;
  localparam logic [3:0] ST_RULE  = 4'd2;
  localparam logic [3:0] ST_CHECK = 4'd3;
  localparam logic [3:0] ST_MUL   = 4'd4;
  localparam logic [3:0] ST_START = 4'd5;
  localparam logic [3:0] ST_WAIT  = 4'd6;
  localparam logic [3:0] ST_APPLY = 4'd7;
  localparam logic [3:0] ST_FLOOR = 4'd8;
  localparam logic [3:0] ST_DONE  = 4'd9;

  localparam logic MODE_QUOT = 1'b0;
  localparam logic MODE_MOD  = 1'b1;

  function automatic logic [W-1:0] sat_add_mss(input logic [W-1:0] a, input logic [15:0] b);
    logic [W:0] s;
    s = {1'b0, a} + WP1'(b);
    return s[W] ? WIN_MAX : s[W-1:0];
  endfunction

  logic [3:0]   state;
  logic [15:0]  cfg_mss;
  logic [7:0]   cfg_min_to;
  logic [7:0]   cfg_max_to;

  phase_t       cur_phase;
  logic [W-1:0] window;
  logic [W-1:0] threshold;
  logic [31:0]  prev_ack;
  logic         ack_seen;
  logic [7:0]   dup_count;
  logic [7:0]   timeout_value;
  logic [7:0]   strikes;

  logic         cmd_q;
  logic [31:0]  ack_q;
  logic         outst_q;
  logic         retx_q;
  logic         stale_q;
  logic         div_mode;
  logic [31:0]  prod;
  logic [N-1:0] scratch;

  logic         div_start;
  logic [N-1:0] div_dividend;
  logic [N-1:0] div_divisor;
  div_status_t  div_status;
  logic [N-1:0] div_quotient;
  logic [N-1:0] div_remainder;

  logic [N-1:0] window_x;
  logic [N-1:0] thresh_x;
  logic [N-1:0] half_x;
  logic [N-1:0] floor2_x;
  logic [N:0]   quot_sum;
  logic [7:0]   strikes_inc;
  logic         out_free;

  assign item_ready   = (state == ST_IDLE);
  assign out_free     = !result_valid || result_ready;
  assign window_x     = N'(window);
  assign thresh_x     = N'(threshold);
  assign half_x       = N'(window >> 1);
  assign floor2_x     = N'({cfg_mss, 1'b0});
  assign quot_sum     = {1'b0, window_x} + {1'b0, div_quotient};
  assign strikes_inc  = (strikes == COUNT_MAX) ? COUNT_MAX : strikes + 8'd1;
  assign div_start    = (state == ST_START);
  assign div_dividend = (div_mode == MODE_MOD) ? half_x : N'(prod);
  assign div_divisor  = (div_mode == MODE_MOD) ? N'(cfg_mss) : window_x;

  tcprw_divider #(
    .WIDTH(N)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .status    (div_status),
    .quotient  (div_quotient),
    .remainder (div_remainder)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_mss    <= RST_SEGMENT_SIZE;
      cfg_min_to <= RST_MIN_TIMEOUT;
      cfg_max_to <= RST_MAX_TIMEOUT;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_SEGMENT_SIZE: cfg_mss    <= cfg_data[15:0];
        CFG_INIT_THRESH:  ;
        CFG_MIN_TIMEOUT:  cfg_min_to <= cfg_data[7:0];
        CFG_MAX_TIMEOUT:  cfg_max_to <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && item_valid) begin
      cmd_q   <= command;
      ack_q   <= ack_number;
      outst_q <= has_outstanding;
    end
    if (state == ST_MUL) begin
      prod <= cfg_mss * cfg_mss;
    end
    if (state == ST_APPLY) begin
      scratch <= half_x - div_remainder;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      cur_phase     <= PH_SLOW;
      window        <= W'(RST_SEGMENT_SIZE);
      threshold     <= W'(RST_INIT_THRESH);
      prev_ack      <= '0;
      ack_seen      <= 1'b0;
      dup_count     <= '0;
      timeout_value <= RST_MIN_TIMEOUT;
      strikes       <= '0;
      retx_q        <= 1'b0;
      stale_q       <= 1'b0;
      div_mode      <= MODE_QUOT;
      result_valid  <= 1'b0;
    end else begin
      if (result_valid && result_ready && state != ST_DONE) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (item_valid) begin
            retx_q  <= 1'b0;
            stale_q <= 1'b0;
            state   <= ST_TRACK;
          end
        end
        ST_TRACK: begin
          if (cmd_q == CMD_ACK) begin
            if (ack_seen && prev_ack > ack_q) begin
              stale_q <= 1'b1;
            end else begin
              if (ack_seen && prev_ack == ack_q) begin
                if (dup_count != COUNT_MAX) begin
                  dup_count <= dup_count + 8'd1;
                end
              end else begin
                dup_count <= '0;
              end
              prev_ack <= ack_q;
              ack_seen <= 1'b1;
            end
            if (timeout_value > cfg_min_to) begin
              strikes       <= '0;
              timeout_value <= timeout_value - 8'd1;
            end
            state <= ST_RULE;
          end else begin
            window    <= W'(cfg_mss);
            cur_phase <= PH_SLOW;
            if (outst_q) begin
              strikes <= strikes_inc;
              if (strikes_inc > STRIKE_LIMIT && timeout_value < cfg_max_to) begin
                timeout_value <= timeout_value + 8'd1;
              end
            end
            state <= ST_DONE;
          end
        end
        ST_RULE: begin
          state <= ST_DONE;
          if (cur_phase == PH_RECOVER) begin
            if (dup_count != '0) begin
              window <= sat_add_mss(window, cfg_mss);
            end else begin
              window    <= sat_add_mss(threshold, cfg_mss);
              cur_phase <= PH_AVOID;
            end
          end else if (dup_count == DUP_TRIGGER) begin
            retx_q <= 1'b1;
            if (cfg_mss == '0) begin
              threshold <= W'(half_x);
              cur_phase <= PH_RECOVER;
            end else begin
              div_mode <= MODE_MOD;
              state    <= ST_START;
            end
          end else if (dup_count == '0) begin
            if (cur_phase == PH_AVOID) begin
              if (window == '0) begin
                window <= WIN_MAX;
              end else begin
                div_mode <= MODE_QUOT;
                state    <= ST_MUL;
              end
            end else begin
              window <= sat_add_mss(window, cfg_mss);
              state  <= ST_CHECK;
            end
          end
        end
        ST_CHECK: begin
          if (window > threshold) begin
            cur_phase <= PH_AVOID;
          end
          state <= ST_DONE;
        end
        ST_MUL: begin
          state <= ST_START;
        end
        ST_START: begin
          state <= ST_WAIT;
        end
        ST_WAIT: begin
          if (div_status.done && !div_status.busy) begin
            state <= ST_APPLY;
          end
        end
        ST_APPLY: begin
          if (div_mode == MODE_MOD) begin
            state <= ST_FLOOR;
          end else begin
            window <= (quot_sum > WIN_MAX_X) ? WIN_MAX : quot_sum[W-1:0];
            state  <= ST_DONE;
          end
        end
        ST_FLOOR: begin
          threshold <= (scratch < floor2_x) ? W'(floor2_x) : W'(scratch);
          cur_phase <= PH_RECOVER;
          state     <= ST_DONE;
        end
        ST_DONE: begin
          if (out_free) begin
            result_valid <= 1'b1;
            state        <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      window_bytes      <= window_x[31:0];
      threshold_bytes   <= thresh_x[31:0];
      phase             <= cur_phase;
      retransmit_oldest <= retx_q;
      ack_stale         <= stale_q;
      duplicate_count   <= dup_count;
      timeout_seconds   <= timeout_value;
    end
  end

endmodule

[rtl/core/tcprw_checker.sv]
// Port-level checks of the Reno congestion window unit, bound to the top level.
`include "assert_macros.svh"

module tcprw_checker
  import tcprw_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        item_valid,
  input logic        item_ready,
  input logic        result_valid,
  input logic        result_ready,
  input logic [31:0] window_bytes,
  input phase_t      phase,
  input logic        retransmit_oldest,
  input logic [7:0]  duplicate_count
);

  `ASSERT_NEXT(a_busy_after_accept, clk, rst, item_valid && item_ready, !item_ready)
  `ASSERT_NEXT(a_result_held, clk, rst, result_valid && !result_ready, result_valid && $stable(window_bytes))
  `ASSERT_IMPLY(a_phase_legal, clk, rst, result_valid, phase == PH_SLOW || phase == PH_AVOID || phase == PH_RECOVER)
  `ASSERT_IMPLY(a_retx_recover, clk, rst, result_valid && retransmit_oldest, phase == PH_RECOVER && duplicate_count == DUP_TRIGGER)

endmodule

bind tcp_reno_congestion_window_unit tcprw_checker u_checker (.*);

[verif/tcp_reno_congestion_window_unit_test.sv]
// Self-checking testbench for the Reno congestion window unit: directed table, then random traffic.
`timescale 1ns / 1ps

module tcp_reno_congestion_window_unit_test;
  import tcprw_pkg::*;

  localparam int SETTLE_CYCLES = 40;
  localparam int RANDOM_PER_PHASE = 270;
  localparam logic [63:0] WIN_LIMIT = 64'hFFFF_FFFF;

  typedef struct packed {
    logic [31:0] window;
    logic [31:0] threshold;
    phase_t      phase;
    logic        retransmit;
    logic        stale;
    logic [7:0]  dups;
    logic [7:0]  rto;
  } window_report_t;

  typedef struct packed {
    logic           is_cfg;
    logic [1:0]     reg_index;
    logic [31:0]    reg_value;
    logic           cmd;
    logic [31:0]    ack;
    logic           outstanding;
    logic           typed;
    window_report_t report;
  } script_row_t;

  localparam script_row_t RENO_SCRIPT [0:27] = '{
    '{1'b0, '0, '0, CMD_ACK, 32'd0, 1'b1, 1'b1,
      '{32'd200, 32'd65535, PH_SLOW, 1'b0, 1'b0, 8'd0, 8'd2}},
    '{1'b0, '0, '0, CMD_ACK, 32'd100, 1'b0, 1'b0, '0},
    '{1'b0, '0, '0, CMD_ACK, 32'd100, 1'b1, 1'b0, '0},
    '{1'b0, '0, '0, CMD_ACK, 32'd100, 1'b0, 1'b0, '0},
    '{1'b0, '0, '0, CMD_ACK, 32'd100, 1'b0, 1'b1,
      '{32'd300, 32'd200, PH_RECOVER, 1'b1, 1'b0, 8'd3, 8'd2}},
    '{1'b0, '0, '0, CMD_ACK, 32'd100, 1'b0, 1'b0, '0},
    '{1'b0, '0, '0, CMD_ACK, 32'd50, 1'b0, 1'b0, '0},
    '{1'b0, '0, '0, CMD_ACK, 32'd200, 1'b0, 1'b0, '0},
    '{1'b0, '0, '0, CMD_ACK, 32'd300, 1'b0, 1'b0, '0},
    '{1'b0, '0, '0, CMD_TIMER, 32'hFFFF_FFFF, 1'b1, 1'b0, '0},
    '{1'b0, '0, '0, CMD_TIMER, 32'h0000_0000, 1'b1, 1'b0, '0},
    '{1'b0, '0, '0, CMD_TIMER, 32'hFFFF_FFFF, 1'b1, 1'b0, '0},
    '{1'b0, '0, '0, CMD_TIMER, 32'h5A5A_A5A5, 1'b1, 1'b0, '0},
    '{1'b0, '0, '0, CMD_TIMER, 32'hA5A5_5A5A, 1'b1, 1'b0, '0},
    '{1'b0, '0, '0, CMD_TIMER, 32'hFFFF_FFFF, 1'b1, 1'b0, '0},
    '{1'b1, CFG_SEGMENT_SIZE, 32'd0, CMD_ACK, '0, 1'b0, 1'b0, '0},
    '{1'b0, '0, '0, CMD_TIMER, 32'h8000_0001, 1'b0, 1'b0, '0},
    '{1'b0, '0, '0, CMD_ACK, 32'd500, 1'b0, 1'b0, '0},
    '{1'b0, '0, '0, CMD_ACK, 32'd500, 1'b0, 1'b0, '0},
    '{1'b0, '0, '0, CMD_ACK, 32'd500, 1'b0, 1'b0, '0},
    '{1'b0, '0, '0, CMD_ACK, 32'd500, 1'b0, 1'b0, '0},
    '{1'b0, '0, '0, CMD_ACK, 32'd600, 1'b0, 1'b0, '0},
    '{1'b0, '0, '0, CMD_ACK, 32'd700, 1'b0, 1'b1,
      '{32'hFFFF_FFFF, 32'd0, PH_AVOID, 1'b0, 1'b0, 8'd0, 8'd2}},
    '{1'b1, CFG_SEGMENT_SIZE, 32'd65535, CMD_ACK, '0, 1'b0, 1'b0, '0},
    '{1'b0, '0, '0, CMD_ACK, 32'd700, 1'b0, 1'b0, '0},
    '{1'b0, '0, '0, CMD_ACK, 32'd700, 1'b0, 1'b0, '0},
    '{1'b0, '0, '0, CMD_ACK, 32'd700, 1'b0, 1'b0, '0},
    '{1'b0, '0, '0, CMD_ACK, 32'd700, 1'b0, 1'b1,
      '{32'hFFFF_FFFF, 32'h7FFF_8000, PH_RECOVER, 1'b0, 1'b0, 8'd4, 8'd2}}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic        item_valid = 1'b0;
  logic        item_ready;
  logic        command = CMD_ACK;
  logic [31:0] ack_number = '0;
  logic        has_outstanding = 1'b0;
  logic        result_valid;
  logic        result_ready = 1'b0;
  logic [31:0] window_bytes;
  logic [31:0] threshold_bytes;
  phase_t      phase;
  logic        retransmit_oldest;
  logic        ack_stale;
  logic [7:0]  duplicate_count;
  logic [7:0]  timeout_seconds;

  tcp_reno_congestion_window_unit dut (
    .clk               (clk),
    .rst               (rst),
    .cfg_write         (cfg_write),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .item_valid        (item_valid),
    .item_ready        (item_ready),
    .command           (command),
    .ack_number        (ack_number),
    .has_outstanding   (has_outstanding),
    .result_valid      (result_valid),
    .result_ready      (result_ready),
    .window_bytes      (window_bytes),
    .threshold_bytes   (threshold_bytes),
    .phase             (phase),
    .retransmit_oldest (retransmit_oldest),
    .ack_stale         (ack_stale),
    .duplicate_count   (duplicate_count),
    .timeout_seconds   (timeout_seconds)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // register copies
  logic [15:0] mss_reg = RST_SEGMENT_SIZE;
  logic [7:0]  min_rto_reg = RST_MIN_TIMEOUT;
  logic [7:0]  max_rto_reg = RST_MAX_TIMEOUT;

  // congestion state
  phase_t      cw_phase = PH_SLOW;
  logic [63:0] cw_window = RST_SEGMENT_SIZE;
  logic [63:0] cw_threshold = RST_INIT_THRESH;
  logic [31:0] prev_ack = '0;
  logic        ack_seen = 1'b0;
  logic [7:0]  dup_count = '0;
  logic [7:0]  rto = RST_MIN_TIMEOUT;
  logic [7:0]  rto_strikes = '0;

  window_report_t window_reports_due [$];
  int          mismatch_count = 0;
  bit          steady_stretch = 1'b0;
  int          ready_hold = 0;
  int          ready_gap;
  logic [31:0] ack_cursor = 32'd700;
  int          dup_run = 0;
  int          timer_run = 0;

  function automatic logic [63:0] sat_window(input logic [63:0] sum);
    return (sum > WIN_LIMIT) ? WIN_LIMIT : sum;
  endfunction

  function automatic int idle_cycles();
    if ($urandom_range(0, 49) == 0) steady_stretch = !steady_stretch;
    return steady_stretch ? 0 : $urandom_range(0, 6);
  endfunction

  task automatic advance_window(input logic cmd, input logic [31:0] ack,
                                input logic outstanding, output window_report_t rep);
    logic        retx;
    logic        stale;
    logic [63:0] seg;
    logic [63:0] quot;
    logic [63:0] half;
    retx = 1'b0;
    stale = 1'b0;
    seg = {48'd0, mss_reg};
    if (cmd == CMD_ACK) begin
      if (ack_seen && prev_ack > ack) begin
        stale = 1'b1;
      end else begin
        if (ack_seen && prev_ack == ack) begin
          if (dup_count != COUNT_MAX) dup_count = dup_count + 8'd1;
        end else begin
          dup_count = '0;
        end
        prev_ack = ack;
        ack_seen = 1'b1;
      end
      case (cw_phase)
        PH_RECOVER: begin
          if (dup_count != 0) begin
            cw_window = sat_window(cw_window + seg);
          end else begin
            cw_window = sat_window(cw_threshold + seg);
            cw_phase = PH_AVOID;
          end
        end
        PH_AVOID: begin
          if (dup_count == DUP_TRIGGER) begin
            retx = 1'b1;
          end else if (dup_count == 0) begin
            quot = (cw_window == 0) ? WIN_LIMIT : (seg * seg) / cw_window;
            cw_window = sat_window(cw_window + quot);
          end
        end
        default: begin
          if (dup_count == DUP_TRIGGER) begin
            retx = 1'b1;
          end else if (dup_count == 0) begin
            cw_window = sat_window(cw_window + seg);
            if (cw_window > cw_threshold) cw_phase = PH_AVOID;
          end
        end
      endcase
      if (retx) begin
        half = cw_window / 2;
        if (seg != 0) half = half - half % seg;
        cw_threshold = (half < 2 * seg) ? 2 * seg : half;
        cw_phase = PH_RECOVER;
      end
      if (rto > min_rto_reg) begin
        rto_strikes = '0;
        rto = rto - 8'd1;
      end
    end else begin
      cw_window = seg;
      cw_phase = PH_SLOW;
      if (outstanding) begin
        if (rto_strikes != COUNT_MAX) rto_strikes = rto_strikes + 8'd1;
        if (rto_strikes > STRIKE_LIMIT && rto < max_rto_reg) rto = rto + 8'd1;
      end
    end
    rep = '{cw_window[31:0], cw_threshold[31:0], cw_phase, retx, stale, dup_count, rto};
  endtask

  task automatic send_item(input logic cmd, input logic [31:0] ack, input logic outstanding,
                           input logic typed, input window_report_t typed_report);
    int             gap;
    window_report_t rep;
    gap = idle_cycles();
    if (gap > 0) begin
      if (item_valid) item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    command <= cmd;
    ack_number <= ack;
    has_outstanding <= outstanding;
    // hold the word until accepted
    do @(posedge clk); while (!item_ready);
    advance_window(cmd, ack, outstanding, rep);
    window_reports_due.push_back(typed ? typed_report : rep);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    case (idx)
      CFG_SEGMENT_SIZE: mss_reg = data[15:0];
      CFG_INIT_THRESH:  ;
      CFG_MIN_TIMEOUT:  min_rto_reg = data[7:0];
      CFG_MAX_TIMEOUT:  max_rto_reg = data[7:0];
      default: ;
    endcase
  endtask

  task automatic settle_block();
    if (item_valid) item_valid <= 1'b0;
    while (window_reports_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic send_random_item();
    logic        cmd;
    logic [31:0] ack;
    logic        outstanding;
    int          pick;
    cmd = CMD_ACK;
    ack = ack_cursor;
    outstanding = $urandom_range(0, 1);
    pick = $urandom_range(0, 99);
    if (dup_run > 0) begin
      dup_run--;
    end else if (timer_run == 0 && pick < 55) begin
      // advance the window edge, now and then by a large step
      ack_cursor = ack_cursor + (($urandom_range(0, 49) == 0) ?
                                 $urandom_range(1, 1 << 24) : $urandom_range(1, 4000));
      ack = ack_cursor;
    end else if (timer_run == 0 && pick < 75) begin
      dup_run = $urandom_range(0, 4);
    end else if (timer_run == 0 && pick < 85) begin
      ack = $urandom_range(ack_cursor - 1);
    end else begin
      outstanding = (timer_run > 0) || ($urandom_range(0, 7) != 0);
      if (timer_run > 0) timer_run--;
      else timer_run = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 7) : 0;
      cmd = CMD_TIMER;
      ack = $urandom;
    end
    send_item(cmd, ack, outstanding, 1'b0, '0);
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      mismatch_count++;
      $display("%0t %s expected %h actual %h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
      ready_hold <= 0;
    end else if (result_valid && result_ready) begin
      ready_gap = idle_cycles();
      result_ready <= (ready_gap == 0);
      ready_hold <= ready_gap;
    end else if (!result_ready) begin
      if (ready_hold > 1) ready_hold <= ready_hold - 1;
      else result_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    window_report_t want;
    if (!rst && result_valid && result_ready) begin
      if (window_reports_due.size() == 0) begin
        mismatch_count++;
        $display("%0t result expected none actual window %h", $time, window_bytes);
      end else begin
        want = window_reports_due.pop_front();
        check_field("window_bytes", want.window, window_bytes);
        check_field("threshold_bytes", want.threshold, threshold_bytes);
        check_field("phase", 32'(want.phase), 32'(phase));
        check_field("retransmit_oldest", 32'(want.retransmit), 32'(retransmit_oldest));
        check_field("ack_stale", 32'(want.stale), 32'(ack_stale));
        check_field("duplicate_count", 32'(want.dups), 32'(duplicate_count));
        check_field("timeout_seconds", 32'(want.rto), 32'(timeout_seconds));
      end
    end
  end

  initial begin
    logic [31:0] seg;
    logic [31:0] thr;
    logic [31:0] lo;
    logic [31:0] hi;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (RENO_SCRIPT[i]) begin
      if (RENO_SCRIPT[i].is_cfg) begin
        settle_block();
        write_reg(RENO_SCRIPT[i].reg_index, RENO_SCRIPT[i].reg_value);
        cfg_write <= 1'b0;
      end else begin
        send_item(RENO_SCRIPT[i].cmd, RENO_SCRIPT[i].ack, RENO_SCRIPT[i].outstanding,
                  RENO_SCRIPT[i].typed, RENO_SCRIPT[i].report);
      end
    end

    for (int p = 0; p < 6; p++) begin
      settle_block();
      case (p)
        0: begin seg = 1460; thr = $urandom; lo = 1; hi = 255; end
        1: begin seg = 1; thr = 32'd0; lo = 255; hi = 1; end
        2: begin seg = 65535; thr = 32'hFFFF_FFFF; lo = 3; hi = 12; end
        3: begin
          seg = $urandom_range(1, 65535);
          thr = $urandom;
          lo = $urandom_range(1, 255);
          hi = $urandom_range(1, 255);
        end
        4: begin seg = 536; thr = 32'd65535; lo = 2; hi = 10; end
        default: begin
          seg = $urandom_range(0, 4);
          thr = $urandom;
          lo = $urandom_range(1, 20);
          hi = $urandom_range(1, 20);
        end
      endcase
      write_reg(CFG_SEGMENT_SIZE, seg);
      write_reg(CFG_INIT_THRESH, thr);
      write_reg(CFG_MIN_TIMEOUT, lo);
      write_reg(CFG_MAX_TIMEOUT, hi);
      cfg_write <= 1'b0;
      // saturate the duplicate count, then the strike count
      if (p == 1) dup_run = 260;
      if (p == 2) timer_run = 260;
      repeat (RANDOM_PER_PHASE) send_random_item();
    end

    send_item(CMD_ACK, 32'hFFFF_FFFF, 1'b1, 1'b0, '0);
    send_item(CMD_ACK, 32'hFFFF_FFFF, 1'b0, 1'b0, '0);
    send_item(CMD_ACK, 32'd0, 1'b0, 1'b0, '0);
    settle_block();

    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
